### rtl/core/cxwc_pkg.sv
// ----------------------------------------------------------------------------
// cxwc_pkg
// Shared types, constants and helpers for the chained XOR word cipher.
// ----------------------------------------------------------------------------
package cxwc_pkg;

  localparam int WORD_W        = 32;
  localparam int KEY_SLOT_W    = 4;
  localparam int BYTE_COUNT_W  = 3;
  localparam int KEY_LENGTH_W  = 5;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 5;
  localparam int KEY_WORDS_DEF = 16;

  localparam logic [WORD_W-1:0] CHAIN_INIT = '1;

  // request kinds
  localparam logic REQ_DATA = 1'b0;
  localparam logic REQ_KEY  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_CIPHER_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_KEY_LENGTH  = 1'd1;

  localparam logic MODE_ENCRYPT = 1'b0;

  localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RST = 5'd1;

  typedef logic [WORD_W-1:0] word_t;

  // Valid low bytes of a last word; zero or four and above means a full word.
  function automatic word_t byte_mask(input logic [BYTE_COUNT_W-1:0] count);
    word_t m;
    unique case (count)
      3'd1:    m = 32'h0000_00FF;
      3'd2:    m = 32'h0000_FFFF;
      3'd3:    m = 32'h00FF_FFFF;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/chained_xor_word_cipher.sv
// ----------------------------------------------------------------------------
// chained_xor_word_cipher
// Streams 32-bit words through key XOR and plaintext chaining with checksum.
//
// Request channel (req_valid / req_stall) carries either a data word or a
// key store write. A key write updates the key store at acceptance and
// produces no result. A data word produces one result on the response
// channel (rsp_valid / rsp_stall): out_word, running_sum and sum_final.
// An accepted data item is registered in the execute stage and then in the
// result register on rsp_*. Throughput: one item per cycle while the response
// side is free; the key store read is issued at acceptance and the chaining
// XOR and checksum add are done in the execute stage. A key write followed
// directly by a data word reading that slot sees the new key.
// When rsp_stall holds, the result stays registered; one more data item
// waits in the execute stage and req_stall rises only then.
// Reset (rst, synchronous) empties both stages, sets chaining to all ones,
// the key pointer and checksum to zero, encrypt mode and key length one.
// Key store contents are not touched by reset.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module chained_xor_word_cipher
  import cxwc_pkg::*;
#(
  parameter int KEY_WORDS = KEY_WORDS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  logic                    req_type,
  input  logic [KEY_SLOT_W-1:0]   key_slot,
  input  logic [WORD_W-1:0]       word_data,
  input  logic [BYTE_COUNT_W-1:0] byte_count,
  input  logic                    buffer_last,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output logic [WORD_W-1:0]       out_word,
  output logic [WORD_W-1:0]       running_sum,
  output logic                    sum_final
);

  localparam int PTR_W = (KEY_WORDS > 1) ? $clog2(KEY_WORDS) : 1;
  localparam int EXT_W = ((PTR_W > KEY_SLOT_W) ? PTR_W : KEY_SLOT_W) + 1;

  logic                    cipher_mode;
  logic [KEY_LENGTH_W-1:0] key_length;

  logic [PTR_W-1:0] key_pointer, key_pointer_next;
  word_t            chain_word, checksum_acc;

  logic  s1_valid, s1_last;
  word_t s1_raw, s1_mask;

  logic accept, data_accept, key_accept, s1_move;

  logic [EXT_W-1:0] slot_ext, len_ext, eff_len, ptr_inc;
  logic [PTR_W-1:0] wr_addr;
  word_t            mask_in, key_word, res, plain, sum;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_mode <= MODE_ENCRYPT;
      key_length  <= KEY_LENGTH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CIPHER_MODE: cipher_mode <= cfg_data[0];
        CFG_KEY_LENGTH:  key_length  <= cfg_data;
        default:         ;
      endcase
    end
  end

  // handshake
  assign s1_move     = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall   = s1_valid && !s1_move;
  assign accept      = req_valid && !req_stall;
  assign data_accept = accept && (req_type == REQ_DATA);

  // key write address
  assign slot_ext   = EXT_W'(key_slot);
  assign wr_addr    = slot_ext[PTR_W-1:0];
  assign key_accept = accept && (req_type == REQ_KEY) && (slot_ext < EXT_W'(KEY_WORDS));

  cxwc_key_store #(
    .DEPTH (KEY_WORDS),
    .AW    (PTR_W)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (key_accept),
    .wr_addr (wr_addr),
    .wr_data (word_data),
    .rd_en   (data_accept),
    .rd_addr (key_pointer),
    .rd_data (key_word)
  );

  // key pointer
  assign len_ext = EXT_W'(key_length);
  always_comb begin
    if (len_ext == '0) begin
      eff_len = EXT_W'(1);
    end else if (len_ext > EXT_W'(KEY_WORDS)) begin
      eff_len = EXT_W'(KEY_WORDS);
    end else begin
      eff_len = len_ext;
    end
    ptr_inc = EXT_W'(key_pointer) + EXT_W'(1);
    if (buffer_last || (ptr_inc >= eff_len)) begin
      key_pointer_next = '0;
    end else begin
      key_pointer_next = ptr_inc[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pointer <= '0;
    end else if (data_accept) begin
      key_pointer <= key_pointer_next;
    end
  end

  // execute stage
  assign mask_in = buffer_last ? byte_mask(byte_count) : '1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (data_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (data_accept) begin
      s1_raw  <= word_data & mask_in;
      s1_mask <= mask_in;
      s1_last <= buffer_last;
    end
  end

  assign res   = (s1_raw ^ key_word ^ chain_word) & s1_mask;
  assign plain = (cipher_mode == MODE_ENCRYPT) ? s1_raw : res;
  assign sum   = checksum_acc + plain;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain_word   <= CHAIN_INIT;
      checksum_acc <= '0;
    end else if (s1_move) begin
      chain_word   <= s1_last ? CHAIN_INIT : plain;
      checksum_acc <= s1_last ? '0 : sum;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_move) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_word    <= res;
      running_sum <= sum;
      sum_final   <= s1_last;
    end
  end

endmodule

### rtl/core/cxwc_key_store.sv
// ----------------------------------------------------------------------------
// cxwc_key_store
// Key word memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module cxwc_key_store
  import cxwc_pkg::*;
#(
  parameter int DEPTH = KEY_WORDS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  word_t         wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output word_t         rd_data
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/cxwc_checker.sv
// ----------------------------------------------------------------------------
// cxwc_checker
// Port-level checks on the cipher's handshake and pipeline behavior.
// ----------------------------------------------------------------------------
module cxwc_checker
  import cxwc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_stall,
  input logic              req_type,
  input logic              rsp_valid,
  input logic              rsp_stall,
  input logic [WORD_W-1:0] out_word,
  input logic [WORD_W-1:0] running_sum,
  input logic              sum_final
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid && !req_stall)
    else $error("result or stall present after reset");

  a_stall_needs_backpressure: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> rsp_valid && rsp_stall)
    else $error("request stalled without a blocked result");

  a_data_gives_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req_type == REQ_DATA)) |-> ##2 rsp_valid)
    else $error("accepted data item did not reach the result register");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=>
      rsp_valid && $stable(out_word) && $stable(running_sum) && $stable(sum_final))
    else $error("stalled result changed");

endmodule

bind chained_xor_word_cipher cxwc_checker u_cxwc_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req_valid),
  .req_stall   (req_stall),
  .req_type    (req_type),
  .rsp_valid   (rsp_valid),
  .rsp_stall   (rsp_stall),
  .out_word    (out_word),
  .running_sum (running_sum),
  .sum_final   (sum_final)
);
